// ----- hdl/cnns_pkg.sv -----
// ----------------------------------------------------------------------------
// cnns_pkg
// Shared types and constants of the cosine nearest-neighbor search block.
// ----------------------------------------------------------------------------
package cnns_pkg;

    localparam int KIND_W     = 2;
    localparam int ELEM_W     = 16;
    localparam int NORM_W     = 36;
    localparam int HALF_W     = NORM_W / 2;
    localparam int PROD_W     = 2 * NORM_W;
    localparam int ROOT_W     = NORM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SCORE_W    = 16;
    localparam int INDEX_W    = 6;
    localparam int DIM_CFG_W  = 6;
    localparam int FRAC_BITS  = 15;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [DIM_CFG_W-1:0] DIM_RESET = DIM_CFG_W'(32);

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_QUERY,
        OP_CLEAR,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [ELEM_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]        best_index;
        logic signed [SCORE_W-1:0] best_similarity;
        logic                      status;
        logic                      store_overflowed;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_ACC,
        ST_QRY_ACC,
        ST_DOT,
        ST_NPROD,
        ST_SQRT,
        ST_DIV,
        ST_SCORE,
        ST_OUT
    } state_t;

endpackage

// ----- hdl/cnns_front.sv -----
// ----------------------------------------------------------------------------
// cnns_front
// Accepts input transfers, decodes the kind and queues work for the back end.
// ----------------------------------------------------------------------------
module cnns_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cnns_pkg::KIND_W-1:0]         s_kind,
    input  logic signed [cnns_pkg::ELEM_W-1:0]  s_value,
    output logic                                q_valid,
    output cnns_pkg::item_t                     q_item,
    input  logic                                q_pop
);

    cnns_pkg::item_t                    queue_reg [cnns_pkg::QDEPTH];
    logic [cnns_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [cnns_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [cnns_pkg::QCNT_W-1:0]        count_reg;
    cnns_pkg::op_t                      op;
    logic                               push;
    logic                               pop;

    always_comb begin
        case (s_kind)
            cnns_pkg::KIND_INSERT: op = cnns_pkg::OP_INSERT;
            cnns_pkg::KIND_QUERY:  op = cnns_pkg::OP_QUERY;
            cnns_pkg::KIND_CLEAR:  op = cnns_pkg::OP_CLEAR;
            default:               op = cnns_pkg::OP_NONE;
        endcase
    end

    assign s_tready = count_reg != cnns_pkg::QCNT_W'(cnns_pkg::QDEPTH);
    assign push     = s_tvalid && s_tready && (op != cnns_pkg::OP_NONE);
    assign q_valid  = count_reg != '0;
    assign pop      = q_pop && q_valid;
    assign q_item   = queue_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= '{op: op, value: s_value};
        end
    end

endmodule

// ----- hdl/cnns_back.sv -----
// ----------------------------------------------------------------------------
// cnns_back
// Vector store, query buffer and the sequential scoring engine.
// ----------------------------------------------------------------------------
module cnns_back #(
    parameter int MAX_VECTORS = 64,
    parameter int MAX_DIM     = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [$clog2(MAX_DIM+1)-1:0]       dim,
    input  logic                               q_valid,
    input  cnns_pkg::item_t                    q_item,
    output logic                               q_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output cnns_pkg::result_t                  m_result
);

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int POS_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int VEC_W   = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int CNT_W   = $clog2(MAX_VECTORS + 1);
    localparam int DEPTH   = MAX_VECTORS * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DOT_W   = 2 * cnns_pkg::ELEM_W + DIM_W + 1;
    localparam int NUM_W   = DOT_W + cnns_pkg::FRAC_BITS;
    localparam int STEP_W  = $clog2(NUM_W + 1);
    localparam int REM_W   = cnns_pkg::ROOT_W + 3;
    localparam int DREM_W  = cnns_pkg::ROOT_W + 1;
    localparam int SQ_W    = 2 * cnns_pkg::ELEM_W;
    localparam int ELEM_W  = cnns_pkg::ELEM_W;
    localparam int NORM_W  = cnns_pkg::NORM_W;
    localparam int HALF_W  = cnns_pkg::HALF_W;
    localparam int PROD_W  = cnns_pkg::PROD_W;
    localparam int ROOT_W  = cnns_pkg::ROOT_W;
    localparam int SCORE_W = cnns_pkg::SCORE_W;

    cnns_pkg::state_t           state_reg, state_next;

    logic [ELEM_W-1:0]          store_mem [DEPTH];
    logic [NORM_W-1:0]          norm_mem [MAX_VECTORS];
    logic signed [ELEM_W-1:0]   query_reg [MAX_DIM];

    logic [CNT_W-1:0]           vec_cnt_reg;
    logic [POS_W-1:0]           ins_pos_reg;
    logic [POS_W-1:0]           qry_pos_reg;
    logic [NORM_W-1:0]          qnorm_reg;
    logic                       ovf_reg;
    logic                       m_valid_reg;
    cnns_pkg::result_t          result_reg;

    logic [SQ_W-1:0]            sq_reg;
    logic [NORM_W-1:0]          ins_norm_reg;
    logic [VEC_W-1:0]           v_reg;
    logic [DIM_W-1:0]           rd_idx_reg;
    logic                       rd_vld_reg;
    logic                       mul_vld_reg;
    logic signed [ELEM_W-1:0]   st_rd_reg;
    logic signed [ELEM_W-1:0]   q_rd_reg;
    logic signed [SQ_W-1:0]     prod_reg;
    logic signed [DOT_W-1:0]    dot_reg;
    logic [NORM_W-1:0]          nv_reg;
    logic                       neg_reg;
    logic                       zero_reg;
    logic [DOT_W-1:0]           mag_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [NORM_W-1:0]          pp_reg;
    logic [PROD_W-1:0]          pacc_reg;
    logic [REM_W-1:0]           srem_reg;
    logic [ROOT_W-1:0]          root_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [NUM_W-1:0]           quo_reg;
    logic [DREM_W-1:0]          drem_reg;
    logic signed [SCORE_W-1:0]  best_score_reg;
    logic [VEC_W-1:0]           best_idx_reg;

    logic                       full;
    logic                       ins_last;
    logic                       qry_last;
    logic                       dot_done;
    logic                       out_load;
    logic [NORM_W-1:0]          ins_norm_new;
    logic [NORM_W-1:0]          qnorm_new;
    logic [ADDR_W-1:0]          ins_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic [HALF_W-1:0]          pa;
    logic [HALF_W-1:0]          pb;
    logic [PROD_W-1:0]          pp_shifted;
    logic [REM_W-1:0]           srem_x;
    logic [REM_W-1:0]           strial;
    logic [DREM_W-1:0]          drem_x;
    logic signed [SCORE_W-1:0]  score;

    assign full     = 32'(vec_cnt_reg) >= MAX_VECTORS;
    assign ins_last = 32'(ins_pos_reg) + 1 >= 32'(dim);
    assign qry_last = 32'(qry_pos_reg) + 1 >= 32'(dim);
    assign dot_done = (rd_idx_reg == dim) && !rd_vld_reg && !mul_vld_reg;

    assign ins_norm_new = ((ins_pos_reg == '0) ? '0 : ins_norm_reg) + NORM_W'(sq_reg);
    assign qnorm_new    = ((qry_pos_reg == '0) ? '0 : qnorm_reg) + NORM_W'(sq_reg);
    assign ins_addr     = ADDR_W'(32'(vec_cnt_reg) * MAX_DIM + 32'(ins_pos_reg));
    assign rd_addr      = ADDR_W'(32'(v_reg) * MAX_DIM + 32'(rd_idx_reg));

    always_comb begin
        pa = qnorm_reg[HALF_W-1:0];
        pb = nv_reg[HALF_W-1:0];
        case (step_reg)
            STEP_W'(1): pb = nv_reg[NORM_W-1:HALF_W];
            STEP_W'(2): pa = qnorm_reg[NORM_W-1:HALF_W];
            STEP_W'(3): begin
                pa = qnorm_reg[NORM_W-1:HALF_W];
                pb = nv_reg[NORM_W-1:HALF_W];
            end
            default: ;
        endcase
    end

    always_comb begin
        case (step_reg)
            STEP_W'(1): pp_shifted = PROD_W'(pp_reg);
            STEP_W'(2),
            STEP_W'(3): pp_shifted = PROD_W'(pp_reg) << HALF_W;
            STEP_W'(4): pp_shifted = PROD_W'(pp_reg) << NORM_W;
            default:    pp_shifted = '0;
        endcase
    end

    assign srem_x = {srem_reg[REM_W-3:0], pacc_reg[PROD_W-1 -: 2]};
    assign strial = REM_W'({root_reg, 2'b01});
    assign drem_x = {drem_reg[DREM_W-2:0], num_reg[NUM_W-1]};

    always_comb begin
        if (zero_reg || root_reg == '0) begin
            score = '0;
        end else if (neg_reg) begin
            score = (quo_reg > NUM_W'(32768)) ? SCORE_W'(-32768)
                                              : -$signed(SCORE_W'(quo_reg));
        end else begin
            score = (quo_reg > NUM_W'(32767)) ? SCORE_W'(32767)
                                              : $signed(SCORE_W'(quo_reg));
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cnns_pkg::ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.op == cnns_pkg::OP_INSERT && !full) begin
                        state_next = cnns_pkg::ST_INS_ACC;
                    end else if (q_item.op == cnns_pkg::OP_QUERY) begin
                        state_next = cnns_pkg::ST_QRY_ACC;
                    end
                end
            end
            cnns_pkg::ST_INS_ACC: state_next = cnns_pkg::ST_IDLE;
            cnns_pkg::ST_QRY_ACC: begin
                if (!qry_last) begin
                    state_next = cnns_pkg::ST_IDLE;
                end else if (vec_cnt_reg == '0) begin
                    state_next = cnns_pkg::ST_OUT;
                end else begin
                    state_next = cnns_pkg::ST_DOT;
                end
            end
            cnns_pkg::ST_DOT: begin
                if (dot_done) begin
                    state_next = cnns_pkg::ST_NPROD;
                end
            end
            cnns_pkg::ST_NPROD: begin
                if (step_reg == STEP_W'(4)) begin
                    state_next = cnns_pkg::ST_SQRT;
                end
            end
            cnns_pkg::ST_SQRT: begin
                if (step_reg == STEP_W'(cnns_pkg::SQRT_STEPS - 1)) begin
                    state_next = cnns_pkg::ST_DIV;
                end
            end
            cnns_pkg::ST_DIV: begin
                if (step_reg == STEP_W'(NUM_W - 1)) begin
                    state_next = cnns_pkg::ST_SCORE;
                end
            end
            cnns_pkg::ST_SCORE: begin
                if (32'(v_reg) + 1 < 32'(vec_cnt_reg)) begin
                    state_next = cnns_pkg::ST_DOT;
                end else begin
                    state_next = cnns_pkg::ST_OUT;
                end
            end
            cnns_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = cnns_pkg::ST_IDLE;
                end
            end
            default: state_next = cnns_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = (state_reg == cnns_pkg::ST_IDLE) && q_valid;
        out_load = (state_reg == cnns_pkg::ST_OUT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cnns_pkg::ST_IDLE;
            vec_cnt_reg <= '0;
            ins_pos_reg <= '0;
            qry_pos_reg <= '0;
            qnorm_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                cnns_pkg::ST_IDLE: begin
                    if (q_valid && q_item.op == cnns_pkg::OP_INSERT && full) begin
                        ovf_reg <= 1'b1;
                    end
                    if (q_valid && q_item.op == cnns_pkg::OP_CLEAR) begin
                        vec_cnt_reg <= '0;
                        ins_pos_reg <= '0;
                        qry_pos_reg <= '0;
                        qnorm_reg   <= '0;
                        ovf_reg     <= 1'b0;
                    end
                end
                cnns_pkg::ST_INS_ACC: begin
                    if (ins_last) begin
                        vec_cnt_reg <= vec_cnt_reg + 1'b1;
                        ins_pos_reg <= '0;
                    end else begin
                        ins_pos_reg <= ins_pos_reg + 1'b1;
                    end
                end
                cnns_pkg::ST_QRY_ACC: begin
                    qnorm_reg   <= qnorm_new;
                    qry_pos_reg <= qry_last ? '0 : qry_pos_reg + 1'b1;
                end
                cnns_pkg::ST_OUT: begin
                    if (out_load) begin
                        qnorm_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        nv_reg <= norm_mem[v_reg];
        case (state_reg)
            cnns_pkg::ST_IDLE: begin
                sq_reg <= SQ_W'(q_item.value * q_item.value);
                if (q_valid && q_item.op == cnns_pkg::OP_INSERT && !full) begin
                    store_mem[ins_addr] <= q_item.value;
                end
                if (q_valid && q_item.op == cnns_pkg::OP_QUERY) begin
                    query_reg[qry_pos_reg] <= q_item.value;
                end
            end
            cnns_pkg::ST_INS_ACC: begin
                norm_mem[vec_cnt_reg[VEC_W-1:0]] <= ins_norm_new;
                ins_norm_reg <= ins_norm_new;
            end
            cnns_pkg::ST_QRY_ACC: begin
                v_reg          <= '0;
                rd_idx_reg     <= '0;
                rd_vld_reg     <= 1'b0;
                mul_vld_reg    <= 1'b0;
                dot_reg        <= '0;
                best_score_reg <= '0;
                best_idx_reg   <= '0;
            end
            cnns_pkg::ST_DOT: begin
                rd_vld_reg <= rd_idx_reg != dim;
                if (rd_idx_reg != dim) begin
                    st_rd_reg  <= store_mem[rd_addr];
                    q_rd_reg   <= query_reg[rd_idx_reg[POS_W-1:0]];
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                mul_vld_reg <= rd_vld_reg;
                if (rd_vld_reg) begin
                    prod_reg <= q_rd_reg * st_rd_reg;
                end
                if (mul_vld_reg) begin
                    dot_reg <= dot_reg + DOT_W'(prod_reg);
                end
                neg_reg  <= dot_reg[DOT_W-1];
                mag_reg  <= dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
                zero_reg <= (qnorm_reg == '0) || (nv_reg == '0);
                step_reg <= '0;
                pacc_reg <= '0;
            end
            cnns_pkg::ST_NPROD: begin
                pp_reg   <= pa * pb;
                pacc_reg <= pacc_reg + pp_shifted;
                srem_reg <= '0;
                root_reg <= '0;
                if (step_reg == STEP_W'(4)) begin
                    step_reg <= '0;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
            cnns_pkg::ST_SQRT: begin
                pacc_reg <= pacc_reg << 2;
                if (srem_x >= strial) begin
                    srem_reg <= srem_x - strial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    srem_reg <= srem_x;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                num_reg  <= NUM_W'(mag_reg) << cnns_pkg::FRAC_BITS;
                quo_reg  <= '0;
                drem_reg <= '0;
                if (step_reg == STEP_W'(cnns_pkg::SQRT_STEPS - 1)) begin
                    step_reg <= '0;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
            cnns_pkg::ST_DIV: begin
                num_reg <= num_reg << 1;
                if (drem_x >= DREM_W'(root_reg)) begin
                    drem_reg <= drem_x - DREM_W'(root_reg);
                    quo_reg  <= {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    drem_reg <= drem_x;
                    quo_reg  <= {quo_reg[NUM_W-2:0], 1'b0};
                end
                step_reg <= step_reg + 1'b1;
            end
            cnns_pkg::ST_SCORE: begin
                if (v_reg == '0 || score > best_score_reg) begin
                    best_score_reg <= score;
                    best_idx_reg   <= v_reg;
                end
                v_reg       <= v_reg + 1'b1;
                rd_idx_reg  <= '0;
                rd_vld_reg  <= 1'b0;
                mul_vld_reg <= 1'b0;
                dot_reg     <= '0;
            end
            cnns_pkg::ST_OUT: begin
                if (out_load) begin
                    result_reg.best_index       <= cnns_pkg::INDEX_W'(best_idx_reg);
                    result_reg.best_similarity  <= best_score_reg;
                    result_reg.status           <= vec_cnt_reg == '0;
                    result_reg.store_overflowed <= ovf_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == cnns_pkg::ST_IDLE) && q_valid)
        else $error("queue popped outside idle");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("result load lost");

    a_ovf_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.op == cnns_pkg::OP_INSERT && full) |=> ovf_reg)
        else $error("overflow not flagged");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cnns_pkg::ST_INS_ACC) |-> !full)
        else $error("insert into full store");

endmodule

// ----- hdl/cosine_nearest_neighbor_search.sv -----
// Insert and query element items pass from the queue through the back end's idle and accumulate states.
// A query's last element scans every stored vector; each vector goes through the dot product,
// the norm product, the bit-serial square root and the divider before its score is compared.
// A four-entry queue decouples input acceptance from the back end.
// Reset (aresetn low, synchronous) empties the store, queue and output; dim_in_use = 32.
// ----------------------------------------------------------------------------
// cosine_nearest_neighbor_search
// Brute-force cosine similarity nearest-neighbor search over a vector store.
// ----------------------------------------------------------------------------
module cosine_nearest_neighbor_search #(
    parameter int MAX_VECTORS = 64,
    parameter int MAX_DIM     = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] element_value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] best_index, [21:6] best_similarity, zero pad
    output logic [1:0]  m_tuser    // [0] status, [1] store_overflowed
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [cnns_pkg::DIM_CFG_W-1:0] dim_reg;
    logic [DIM_W-1:0]               dim_eff;
    logic                           q_valid;
    logic                           q_pop;
    cnns_pkg::item_t                q_item;
    cnns_pkg::result_t              result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= cnns_pkg::DIM_RESET;
        end else if (cfg_wr_en) begin
            dim_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (dim_reg == '0) begin
            dim_eff = DIM_W'(1);
        end else if (32'(dim_reg) > MAX_DIM) begin
            dim_eff = DIM_W'(MAX_DIM);
        end else begin
            dim_eff = DIM_W'(dim_reg);
        end
    end

    cnns_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .s_value  ($signed(s_tdata)),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    cnns_back #(
        .MAX_VECTORS (MAX_VECTORS),
        .MAX_DIM     (MAX_DIM)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dim      (dim_eff),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {2'b00, result.best_similarity, result.best_index};
    assign m_tuser = {result.store_overflowed, result.status};

endmodule
